// File: design/pid_pkg.sv
// Shared types and constants of the clamped PID controller.
package pid_pkg;

  // Fixed-point formats of the coefficient registers.
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned LIMIT_W   = 15;
  localparam int unsigned SUM_W     = 32;
  localparam int unsigned GAIN_FRAC = 12;
  localparam int unsigned TS_FRAC   = 16;
  localparam int unsigned INV_FRAC  = 8;
  localparam int unsigned IDX_W     = 3;

  // Reset values of the coefficient registers.
  localparam logic [COEF_W-1:0] GAIN_P_RST = 16'd2867;
  localparam logic [COEF_W-1:0] GAIN_I_RST = 16'd614;
  localparam logic [COEF_W-1:0] GAIN_D_RST = 16'd3686;
  localparam logic [COEF_W-1:0] TS_RST     = 16'd6554;
  localparam logic [COEF_W-1:0] INV_TS_RST = 16'd2560;

  typedef enum logic [IDX_W-1:0] {
    REG_SETPOINT    = 3'd0,
    REG_GAIN_P      = 3'd1,
    REG_GAIN_I      = 3'd2,
    REG_GAIN_D      = 3'd3,
    REG_TS          = 3'd4,
    REG_INV_TS      = 3'd5,
    REG_DRIVE_LIMIT = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [COEF_W-1:0]  gain_p;
    logic [COEF_W-1:0]  gain_i;
    logic [COEF_W-1:0]  gain_d;
    logic [COEF_W-1:0]  sample_period;
    logic [COEF_W-1:0]  inv_sample_period;
    logic [LIMIT_W-1:0] drive_limit;
  } coef_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_TS,
    ST_SUM,
    ST_DER,
    ST_ACC_P,
    ST_ACC_I,
    ST_ACC_D,
    ST_DONE
  } seq_state_e;

  typedef enum logic [2:0] {
    MUL_ERR_TS,
    MUL_DIFF_INV,
    MUL_ERR_GP,
    MUL_SUM_GI,
    MUL_DER_GD
  } mul_sel_e;

  typedef struct packed {
    logic     in_ready;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     diff_en;
    logic     sum_en;
    logic     der_en;
    logic     acc_ld;
    logic     acc_add;
    logic     out_ld;
  } ctrl_t;

endpackage

// File: design/pid_if.sv
// Channel interfaces of the PID controller: sample in, drive out, register writes.
interface pid_meas_if #(parameter int unsigned DW = 16);
  logic          valid;
  logic          ready;
  logic [DW-1:0] measured;
  modport source (output valid, output measured, input ready);
  modport sink   (input valid, input measured, output ready);
endinterface

interface pid_drive_if #(parameter int unsigned DW = 16);
  logic          valid;
  logic          ready;
  logic [DW-1:0] drive;
  logic          clamped;
  modport source (output valid, output drive, output clamped, input ready);
  modport sink   (input valid, input drive, input clamped, output ready);
endinterface

interface pid_cfg_if #(parameter int unsigned CW = 16);
  logic          valid;
  logic          ready;
  logic [2:0]    index;
  logic [CW-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// File: design/pid_regs.sv
// Configuration register file of the PID controller.
module pid_regs #(
  parameter int unsigned DW   = 16,
  parameter int unsigned FRAC = 10,
  parameter int unsigned CW   = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      wr_en_i,
  input  logic [pid_pkg::IDX_W-1:0] wr_idx_i,
  input  logic [CW-1:0]             wr_data_i,
  output logic [DW-1:0]             setpoint_o,
  output pid_pkg::coef_t            coef_o
);

  localparam logic [DW-1:0] SETPOINT_RST = DW'(64'(1) << FRAC);
  localparam logic [pid_pkg::LIMIT_W-1:0] LIMIT_RST =
    pid_pkg::LIMIT_W'(64'(10) << FRAC);

  logic [DW-1:0]  setpoint_q, setpoint_d;
  pid_pkg::coef_t coef_q, coef_d;

  always_comb begin
    setpoint_d = setpoint_q;
    coef_d     = coef_q;
    if (wr_en_i) begin
      unique case (pid_pkg::cfg_idx_e'(wr_idx_i))
        pid_pkg::REG_SETPOINT:    setpoint_d = wr_data_i[DW-1:0];
        pid_pkg::REG_GAIN_P:      coef_d.gain_p = wr_data_i[pid_pkg::COEF_W-1:0];
        pid_pkg::REG_GAIN_I:      coef_d.gain_i = wr_data_i[pid_pkg::COEF_W-1:0];
        pid_pkg::REG_GAIN_D:      coef_d.gain_d = wr_data_i[pid_pkg::COEF_W-1:0];
        pid_pkg::REG_TS:          coef_d.sample_period = wr_data_i[pid_pkg::COEF_W-1:0];
        pid_pkg::REG_INV_TS:      coef_d.inv_sample_period = wr_data_i[pid_pkg::COEF_W-1:0];
        pid_pkg::REG_DRIVE_LIMIT: coef_d.drive_limit = wr_data_i[pid_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q               <= SETPOINT_RST;
      coef_q.gain_p            <= pid_pkg::GAIN_P_RST;
      coef_q.gain_i            <= pid_pkg::GAIN_I_RST;
      coef_q.gain_d            <= pid_pkg::GAIN_D_RST;
      coef_q.sample_period     <= pid_pkg::TS_RST;
      coef_q.inv_sample_period <= pid_pkg::INV_TS_RST;
      coef_q.drive_limit       <= LIMIT_RST;
    end else begin
      setpoint_q <= setpoint_d;
      coef_q     <= coef_d;
    end
  end

  assign setpoint_o = setpoint_q;
  assign coef_o     = coef_q;

endmodule

// File: design/pid_mul.sv
// Shared signed-by-unsigned multiplier with a registered product.
module pid_mul #(
  parameter int unsigned AW = 34
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [AW-1:0]               a_i,
  input  logic [pid_pkg::COEF_W-1:0]         b_i,
  output logic signed [AW+pid_pkg::COEF_W-1:0] prod_o
);

  localparam int unsigned PW = AW + pid_pkg::COEF_W;

  logic signed [PW:0]   full;
  logic signed [PW-1:0] prod_q;

  // The coefficient is unsigned, so the product fits in one bit less than the full width.
  assign full = a_i * $signed({1'b0, b_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= full[PW-1:0];
    end
  end

  assign prod_o = prod_q;

endmodule

// File: design/pid_seq.sv
// Step sequencer that drives the shared multiplier and the accumulators.
module pid_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_free_i,
  output pid_pkg::ctrl_t  ctrl_o
);

  pid_pkg::seq_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pid_pkg::ST_IDLE:   if (in_valid_i) state_d = pid_pkg::ST_MUL_TS;
      pid_pkg::ST_MUL_TS: state_d = pid_pkg::ST_SUM;
      pid_pkg::ST_SUM:    state_d = pid_pkg::ST_DER;
      pid_pkg::ST_DER:    state_d = pid_pkg::ST_ACC_P;
      pid_pkg::ST_ACC_P:  state_d = pid_pkg::ST_ACC_I;
      pid_pkg::ST_ACC_I:  state_d = pid_pkg::ST_ACC_D;
      pid_pkg::ST_ACC_D:  state_d = pid_pkg::ST_DONE;
      pid_pkg::ST_DONE:   if (out_free_i) state_d = pid_pkg::ST_IDLE;
      default:            state_d = pid_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o         = '0;
    ctrl_o.mul_sel = pid_pkg::MUL_ERR_TS;
    unique case (state_q)
      pid_pkg::ST_IDLE:   ctrl_o.in_ready = 1'b1;
      pid_pkg::ST_MUL_TS: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.diff_en = 1'b1;
      end
      pid_pkg::ST_SUM: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = pid_pkg::MUL_DIFF_INV;
        ctrl_o.sum_en  = 1'b1;
      end
      pid_pkg::ST_DER: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = pid_pkg::MUL_ERR_GP;
        ctrl_o.der_en  = 1'b1;
      end
      pid_pkg::ST_ACC_P: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = pid_pkg::MUL_SUM_GI;
        ctrl_o.acc_ld  = 1'b1;
      end
      pid_pkg::ST_ACC_I: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = pid_pkg::MUL_DER_GD;
        ctrl_o.acc_add = 1'b1;
      end
      pid_pkg::ST_ACC_D:  ctrl_o.acc_add = 1'b1;
      pid_pkg::ST_DONE:   ctrl_o.out_ld = out_free_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pid_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/pid_controller_clamped.sv
// Top level of the positional PID controller with a symmetric output clamp.
//
// Each accepted measured sample (signed, FRAC_BITS fraction bits) produces exactly one
// drive transaction. The error against the setpoint register is scaled by the sample
// period and added into a saturating 32-bit integral; the error difference against the
// previous sample is scaled by the reciprocal sample period and saturated to 32 bits.
// The three terms are weighted by the Q4.12 gains, summed exactly, shifted down by 12
// with rounding toward minus infinity, and clamped to +/-drive_limit (further capped at
// the largest positive DATA_WIDTH value); clamped is set when the clamp acted. One
// sample passes through the idle state that accepts it and then seven sequencer
// steps, five of which use the single shared multiplier one product at a time. The
// input is not ready during those steps. A finished result sits in an output register,
// so the next sample is accepted while it waits; if the previous result has not been
// taken by the time the next one is finished, the sequencer holds in its last step.
// Registers may be written only while no sample is in flight and no result is pending.
module pid_controller_clamped #(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 10
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pid_meas_if.sink     in_i,
  pid_drive_if.source  out_o,
  pid_cfg_if.sink      cfg_i
);

  localparam int unsigned DW   = DATA_WIDTH;
  localparam int unsigned CW   = (DW > pid_pkg::COEF_W) ? DW : pid_pkg::COEF_W;
  localparam int unsigned EW   = DW + 1;           // error
  localparam int unsigned DFW  = DW + 2;           // error difference
  localparam int unsigned MAW  = (DFW > pid_pkg::SUM_W) ? DFW : pid_pkg::SUM_W;
  localparam int unsigned PW   = MAW + pid_pkg::COEF_W;
  localparam int unsigned ACCW = PW + 2;
  localparam int unsigned SATW = MAW + 9;
  localparam int unsigned SW   = pid_pkg::SUM_W;

  // Register file.
  logic [DW-1:0]  setpoint;
  pid_pkg::coef_t coef;

  assign cfg_i.ready = 1'b1;

  pid_regs #(.DW(DW), .FRAC(FRAC_BITS), .CW(CW)) u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_idx_i   (cfg_i.index),
    .wr_data_i  (cfg_i.wdata),
    .setpoint_o (setpoint),
    .coef_o     (coef)
  );

  // Sequencer.
  pid_pkg::ctrl_t ctrl;
  logic           out_valid_q, out_valid_d;
  logic           out_free;
  logic           in_fire;

  assign out_free = !out_valid_q || out_o.ready;

  pid_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  assign in_i.ready = ctrl.in_ready;
  assign in_fire    = in_i.valid && ctrl.in_ready;

  // Datapath registers.
  logic signed [EW-1:0]   err_q, last_err_q;
  logic signed [DFW-1:0]  diff_q;
  logic signed [SW-1:0]   sum_q, deriv_q;
  logic signed [ACCW-1:0] acc_q;
  logic signed [DW-1:0]   drive_q;
  logic                   clamped_q;

  // Shared multiplier and its operand select.
  logic signed [MAW-1:0]          mul_a;
  logic [pid_pkg::COEF_W-1:0]     mul_b;
  logic signed [PW-1:0]           prod;

  always_comb begin
    mul_a = MAW'(err_q);
    mul_b = coef.sample_period;
    case (ctrl.mul_sel)
      pid_pkg::MUL_ERR_TS: begin
        mul_a = MAW'(err_q);
        mul_b = coef.sample_period;
      end
      pid_pkg::MUL_DIFF_INV: begin
        mul_a = MAW'(diff_q);
        mul_b = coef.inv_sample_period;
      end
      pid_pkg::MUL_ERR_GP: begin
        mul_a = MAW'(err_q);
        mul_b = coef.gain_p;
      end
      pid_pkg::MUL_SUM_GI: begin
        mul_a = MAW'(sum_q);
        mul_b = coef.gain_i;
      end
      pid_pkg::MUL_DER_GD: begin
        mul_a = MAW'(deriv_q);
        mul_b = coef.gain_d;
      end
      default: ;
    endcase
  end

  pid_mul #(.AW(MAW)) u_mul (
    .clk_i  (clk_i),
    .en_i   (ctrl.mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Saturation of a wide intermediate to the signed 32-bit range.
  function automatic logic signed [SW-1:0] sat32(input logic signed [SATW-1:0] v);
    logic signed [SW-1:0] r;
    if (v[SATW-1:SW-1] == {(SATW-SW+1){v[SATW-1]}}) begin
      r = v[SW-1:0];
    end else if (v[SATW-1]) begin
      r = {1'b1, {(SW-1){1'b0}}};
    end else begin
      r = {1'b0, {(SW-1){1'b1}}};
    end
    return r;
  endfunction

  // Shifting by the fraction widths is a plain part-select of the product, which
  // rounds toward minus infinity.
  logic signed [SATW-1:0] sum_next, deriv_next;

  assign sum_next   = SATW'(sum_q) + SATW'($signed(prod[PW-1:pid_pkg::TS_FRAC]));
  assign deriv_next = SATW'($signed(prod[PW-1:pid_pkg::INV_FRAC]));

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      err_q <= EW'($signed(setpoint)) - EW'($signed(in_i.measured));
    end
    if (ctrl.diff_en) begin
      diff_q <= DFW'(err_q) - DFW'(last_err_q);
    end
    if (ctrl.der_en) begin
      deriv_q <= sat32(deriv_next);
    end
    if (ctrl.acc_ld) begin
      acc_q <= ACCW'(prod);
    end else if (ctrl.acc_add) begin
      acc_q <= acc_q + ACCW'(prod);
    end
  end

  // Controller state: previous error and integral, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
      sum_q      <= '0;
    end else begin
      if (ctrl.diff_en) begin
        last_err_q <= err_q;
      end
      if (ctrl.sum_en) begin
        sum_q <= sat32(sum_next);
      end
    end
  end

  // Clamp. The effective limit is the register capped at the largest positive value.
  logic signed [ACCW-1:0] drive_full, lim_reg, lim_max, lim;
  logic signed [DW-1:0]   drive_d;
  logic                   clamped_d;

  assign drive_full = acc_q >>> pid_pkg::GAIN_FRAC;
  assign lim_reg    = ACCW'(coef.drive_limit);
  assign lim_max    = ACCW'({1'b0, {(DW-1){1'b1}}});
  assign lim        = (lim_reg > lim_max) ? lim_max : lim_reg;

  always_comb begin
    drive_d   = drive_full[DW-1:0];
    clamped_d = 1'b0;
    if (drive_full > lim) begin
      drive_d   = lim[DW-1:0];
      clamped_d = 1'b1;
    end else if (drive_full < -lim) begin
      drive_d   = DW'(-lim);
      clamped_d = 1'b1;
    end
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_ld) begin
      drive_q   <= drive_d;
      clamped_q <= clamped_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.drive   = drive_q;
  assign out_o.clamped = clamped_q;

  // Only one sample is in flight: after an accepted transaction the input is not ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("input accepted while a sample is in flight");

  // A result becomes valid only from the final sequencer step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(ctrl.out_ld))
    else $error("result valid without a finished computation");

  // The delivered drive never exceeds the effective limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (ACCW'($signed(out_o.drive)) <= lim &&
                     ACCW'($signed(out_o.drive)) >= -lim))
    else $error("drive outside the clamp limit");

  // A clamped result sits exactly on one of the two limits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.clamped) |->
      (ACCW'($signed(out_o.drive)) == lim || ACCW'($signed(out_o.drive)) == -lim))
    else $error("clamped flag set but drive is not at a limit");

endmodule

// File: tb/sv/pid_controller_clamped_tb.sv
// Self-checking testbench of the clamped positional PID controller.
module pid_controller_clamped_tb;

  // The block runs at its default data format.
  localparam int unsigned DATA_W = 16;
  localparam int unsigned FRAC_W = 10;
  localparam longint      MAX_POS = (longint'(1) << (DATA_W - 1)) - 1;
  localparam longint      SUM_MAX = 64'sd2147483647;
  localparam longint      SUM_MIN = -64'sd2147483648;

  // The index field has room for one register that does not exist.
  localparam logic [pid_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;

  // Generous run limit, several times the slowest legal run.
  localparam longint RUN_LIMIT = 64'd10_000_000;

  typedef struct packed {
    logic [DATA_W-1:0] drive;
    logic              clamped;
  } drive_exp_t;

  logic clk_i;
  logic rst_ni;

  pid_meas_if  #(.DW(DATA_W)) meas_if ();
  pid_drive_if #(.DW(DATA_W)) drv_if ();
  pid_cfg_if   #(.CW(pid_pkg::COEF_W)) cfg_if ();

  pid_controller_clamped #(
    .DATA_WIDTH(DATA_W),
    .FRAC_BITS (FRAC_W)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (meas_if),
    .out_o (drv_if),
    .cfg_i (cfg_if)
  );

  // Shadow copy of the coefficient registers, kept up to date by watching the
  // register write channel. The values start at their reset defaults.
  logic [DATA_W-1:0]           setpoint_q = DATA_W'(1 << FRAC_W);
  logic [pid_pkg::COEF_W-1:0]  gain_p_q   = pid_pkg::GAIN_P_RST;
  logic [pid_pkg::COEF_W-1:0]  gain_i_q   = pid_pkg::GAIN_I_RST;
  logic [pid_pkg::COEF_W-1:0]  gain_d_q   = pid_pkg::GAIN_D_RST;
  logic [pid_pkg::COEF_W-1:0]  ts_q       = pid_pkg::TS_RST;
  logic [pid_pkg::COEF_W-1:0]  inv_ts_q   = pid_pkg::INV_TS_RST;
  logic [pid_pkg::LIMIT_W-1:0] limit_q    = pid_pkg::LIMIT_W'(10 << FRAC_W);

  // Controller state as the block should hold it: the previous error and the
  // saturating integral.
  logic signed [DATA_W:0]           prev_err_q     = '0;
  logic signed [pid_pkg::SUM_W-1:0] err_integral_q = '0;

  // Drive values predicted for accepted samples, oldest first.
  drive_exp_t pending_drive_q[$];

  int unsigned mismatch_count = 0;
  int unsigned drives_seen    = 0;

  // When set, neither side inserts random idle cycles.
  bit          quiet_mode    = 1'b0;
  // A nonzero value asks the drive sink for one long hold-off of that many cycles.
  int unsigned sink_hold_req = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // The hard stop. It only fires if the run hangs.
  initial begin
    #(RUN_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("ERROR @%0t: %s", $time, what);
  endtask

  function automatic longint clip_to_32(input longint v);
    if (v > SUM_MAX) return SUM_MAX;
    if (v < SUM_MIN) return SUM_MIN;
    return v;
  endfunction

  // Works out the drive for one sample and advances the shadow state. The error is
  // exact; the integral step and the derivative round toward minus infinity, which
  // is what an arithmetic right shift of a signed value gives.
  function automatic drive_exp_t predict_drive(input logic [DATA_W-1:0] sample);
    longint     err;
    longint     integral;
    longint     deriv;
    longint     acc;
    longint     drv;
    longint     lim;
    drive_exp_t res;
    err      = longint'($signed(setpoint_q)) - longint'($signed(sample));
    integral = clip_to_32(longint'(err_integral_q)
                          + ((err * longint'(ts_q)) >>> pid_pkg::TS_FRAC));
    deriv    = clip_to_32(((err - longint'(prev_err_q)) * longint'(inv_ts_q))
                          >>> pid_pkg::INV_FRAC);
    err_integral_q = integral[pid_pkg::SUM_W-1:0];
    prev_err_q     = err[DATA_W:0];
    acc = longint'(gain_p_q) * err + longint'(gain_i_q) * integral
          + longint'(gain_d_q) * deriv;
    drv = acc >>> pid_pkg::GAIN_FRAC;
    lim = longint'(limit_q);
    if (lim > MAX_POS) lim = MAX_POS;
    res.clamped = 1'b0;
    // A sum sitting exactly on a limit passes without the flag.
    if (drv > lim) begin
      drv         = lim;
      res.clamped = 1'b1;
    end
    if (drv < -lim) begin
      drv         = -lim;
      res.clamped = 1'b1;
    end
    res.drive = drv[DATA_W-1:0];
    return res;
  endfunction

  // Register writes land in the shadow copy at the edge that completes the
  // transaction. A write to the unused index changes nothing.
  always @(posedge clk_i) begin
    if (rst_ni && cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        pid_pkg::REG_SETPOINT:    setpoint_q = cfg_if.wdata[DATA_W-1:0];
        pid_pkg::REG_GAIN_P:      gain_p_q   = cfg_if.wdata;
        pid_pkg::REG_GAIN_I:      gain_i_q   = cfg_if.wdata;
        pid_pkg::REG_GAIN_D:      gain_d_q   = cfg_if.wdata;
        pid_pkg::REG_TS:          ts_q       = cfg_if.wdata;
        pid_pkg::REG_INV_TS:      inv_ts_q   = cfg_if.wdata;
        pid_pkg::REG_DRIVE_LIMIT: limit_q    = cfg_if.wdata[pid_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Every accepted sample yields exactly one expected drive.
  always @(posedge clk_i) begin
    if (rst_ni && meas_if.valid && meas_if.ready) begin
      pending_drive_q.push_back(predict_drive(meas_if.measured));
    end
  end

  // Each drive transaction is matched against the oldest prediction.
  always @(posedge clk_i) begin : drive_checker
    drive_exp_t want;
    if (rst_ni && drv_if.valid && drv_if.ready) begin
      drives_seen++;
      if (pending_drive_q.size() == 0) begin
        report_mismatch($sformatf("drive %0d arrived with no sample pending",
                                  $signed(drv_if.drive)));
      end else begin
        want = pending_drive_q.pop_front();
        if (drv_if.drive !== want.drive) begin
          report_mismatch($sformatf("drive #%0d: got %0d, want %0d", drives_seen,
                                    $signed(drv_if.drive), $signed(want.drive)));
        end
        if (drv_if.clamped !== want.clamped) begin
          report_mismatch($sformatf("drive #%0d: clamped got %b, want %b", drives_seen,
                                    drv_if.clamped, want.clamped));
        end
      end
    end
  end

  // Drive sink. Before each transaction it draws a random stall, unless the
  // quiet mode is on. A pending hold-off request replaces the draw once, which
  // lets the block fill up and push back on its sample input.
  initial begin : drive_sink
    int unsigned stall;
    drv_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (sink_hold_req != 0) begin
        stall         = sink_hold_req;
        sink_hold_req = 0;
      end else begin
        stall = quiet_mode ? 0 : $urandom_range(0, 11);
      end
      if (stall != 0) begin
        drv_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      drv_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!drv_if.valid) @(posedge clk_i);
    end
  end

  // Offers one sample after a random gap and returns at the edge that accepts
  // it. Valid stays high on return; the caller either offers the next sample in
  // the same step or lowers valid through wait_results.
  task automatic send_sample(input logic [DATA_W-1:0] sample);
    int unsigned gap;
    gap = quiet_mode ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      meas_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    meas_if.valid    <= 1'b1;
    meas_if.measured <= sample;
    @(posedge clk_i);
    while (!meas_if.ready) @(posedge clk_i);
  endtask

  // Stops offering samples and waits until every predicted drive has arrived.
  // With nothing in flight the block is idle and may take register writes.
  task automatic wait_results();
    meas_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_drive_q.size() != 0) @(posedge clk_i);
  endtask

  // One register write transaction. Valid is left high so that writes can follow
  // back to back; end_writes lowers it.
  task automatic write_reg(input logic [pid_pkg::IDX_W-1:0] idx,
                           input logic [pid_pkg::COEF_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  task automatic end_writes();
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [pid_pkg::COEF_W-1:0] sp,
                          input logic [pid_pkg::COEF_W-1:0] gp,
                          input logic [pid_pkg::COEF_W-1:0] gi,
                          input logic [pid_pkg::COEF_W-1:0] gd,
                          input logic [pid_pkg::COEF_W-1:0] ts,
                          input logic [pid_pkg::COEF_W-1:0] inv_ts,
                          input logic [pid_pkg::COEF_W-1:0] lim);
    write_reg(pid_pkg::REG_SETPOINT, sp);
    write_reg(pid_pkg::REG_GAIN_P, gp);
    write_reg(pid_pkg::REG_GAIN_I, gi);
    write_reg(pid_pkg::REG_GAIN_D, gd);
    write_reg(pid_pkg::REG_TS, ts);
    write_reg(pid_pkg::REG_INV_TS, inv_ts);
    write_reg(pid_pkg::REG_DRIVE_LIMIT, lim);
    end_writes();
  endtask

  // Register values for the random phases: zeros and full scale come up often,
  // and small gains keep a fair share of the drives inside the clamp.
  function automatic logic [pid_pkg::COEF_W-1:0] pick_coef(input int unsigned max_val);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return pid_pkg::COEF_W'(max_val);
      2, 3:    return pid_pkg::COEF_W'($urandom_range(0, max_val));
      default: return pid_pkg::COEF_W'($urandom_range(0, max_val / 8));
    endcase
  endfunction

  // Samples for the random phases: anywhere in range, near the setpoint, the
  // range ends, or a slow drift from the previous sample.
  function automatic logic [DATA_W-1:0] pick_sample(input logic [DATA_W-1:0] prev);
    case ($urandom_range(0, 4))
      0: return DATA_W'($urandom());
      1: return setpoint_q + DATA_W'($urandom_range(0, 511)) - DATA_W'(256);
      2: begin
        case ($urandom_range(0, 3))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      default: return prev + DATA_W'($urandom_range(0, 127)) - DATA_W'(64);
    endcase
  endfunction

  // Straight out of reset: zero error first, so the derivative is taken against
  // a cleared previous error, then the ends of the sample range.
  task automatic test_reset_defaults();
    send_sample(16'd1024);
    send_sample(16'd0);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'hFFFF);
    wait_results();
  endtask

  // A write to the index with no register behind it must leave every
  // coefficient as it was.
  task automatic test_unknown_index();
    write_reg(REG_UNUSED, 16'hFFFF);
    end_writes();
    send_sample(16'd0);
    send_sample(16'd1024);
    wait_results();
  endtask

  // With a unit proportional gain and the other terms off, the drive equals the
  // error, so it can be placed exactly on and just past each limit.
  task automatic test_clamp_edges();
    set_regs(16'd0, 16'd4096, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1000);
    send_sample(-16'sd1000);
    send_sample(-16'sd1001);
    send_sample(16'sd1000);
    send_sample(16'sd1001);
    send_sample(16'd0);
    wait_results();
    // A zero limit pins every nonzero drive to zero with the flag set.
    write_reg(pid_pkg::REG_DRIVE_LIMIT, 16'd0);
    end_writes();
    send_sample(16'd0);
    send_sample(16'd1);
    send_sample(16'hFFFF);
    wait_results();
  endtask

  // Zero sample period and zero reciprocal: under large integral and derivative gains
  // the integral must hold still and the derivative stay zero, whatever the error does.
  task automatic test_zero_periods();
    set_regs(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'd0);
    wait_results();
  endtask

  // Every register at full scale, with the error swinging between its extremes.
  task automatic test_field_extremes();
    set_regs(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    wait_results();
    write_reg(pid_pkg::REG_SETPOINT, 16'h8000);
    end_writes();
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    wait_results();
  endtask

  // The sink holds off for a long stretch while samples keep coming: one result
  // waits in the output register, the next one stalls the sequencer, and the
  // sample input has to back off.
  task automatic test_backpressure();
    set_regs(16'd512, 16'd2867, 16'd614, 16'd3686, 16'd6554, 16'd2560, 16'd10240);
    quiet_mode    = 1'b1;
    sink_hold_req = 300;
    for (int i = 0; i < 24; i++) begin
      send_sample(DATA_W'($urandom()));
    end
    wait_results();
    quiet_mode = 1'b0;
  endtask

  // Winds the integral up with the largest positive error, then back down
  // through zero into large negative sums with the largest negative error.
  // Each sample moves the integral by about 65534, so full saturation would
  // take some 32768 samples; this phase covers the large sums on the way.
  // With only a tiny integral gain the drive follows the integral, so a
  // truncated or wrapped sum shows at once as a wrong drive.
  task automatic test_integral_windup();
    quiet_mode = 1'b1;
    set_regs(16'h7FFF, 16'd0, 16'd1, 16'd0, 16'hFFFF, 16'd0, 16'h7FFF);
    for (int i = 0; i < 100; i++) begin
      send_sample(16'h8000);
    end
    wait_results();
    write_reg(pid_pkg::REG_SETPOINT, 16'h8000);
    end_writes();
    for (int i = 0; i < 200; i++) begin
      send_sample(16'h7FFF);
    end
    wait_results();
    quiet_mode = 1'b0;
  endtask

  // Random phases, each under freshly drawn register values. Every fourth phase
  // runs without idle cycles, and now and then the sender pauses until all
  // outstanding drives are back.
  task automatic test_random_phases();
    logic [DATA_W-1:0] sample;
    sample = '0;
    for (int phase = 0; phase < 10; phase++) begin
      quiet_mode = (phase % 4 == 3);
      set_regs(pick_coef(16'hFFFF), pick_coef(16'hFFFF), pick_coef(16'hFFFF),
               pick_coef(16'hFFFF), pick_coef(16'hFFFF), pick_coef(16'hFFFF),
               pick_coef(16'hFFFF));
      for (int i = 0; i < 130; i++) begin
        sample = pick_sample(sample);
        send_sample(sample);
        if ($urandom_range(0, 39) == 0) begin
          wait_results();
        end
      end
      wait_results();
    end
    quiet_mode = 1'b0;
  endtask

  initial begin
    meas_if.valid    <= 1'b0;
    meas_if.measured <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= '0;
    cfg_if.wdata     <= '0;
    rst_ni           <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_unknown_index();
    test_clamp_edges();
    test_zero_periods();
    test_field_extremes();
    test_backpressure();
    test_integral_windup();
    test_random_phases();

    // Everything predicted has arrived; give a stray extra transaction time to
    // show up before the verdict.
    wait_results();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
design/pid_pkg.sv
design/pid_if.sv
design/pid_regs.sv
design/pid_mul.sv
design/pid_seq.sv
design/pid_controller_clamped.sv
tb/sv/pid_controller_clamped_tb.sv
